[rtl/msd_pkg.sv]
// package for the date merge sorter: record type, queue entry and tally limits
// no dependencies
package msd_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned TallyW = 9;
  localparam logic [TallyW-1:0] TallyMax = '1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
  } rec_t;

  // entry handed from the load front to the sort back
  typedef struct packed {
    rec_t rec;
    logic last;
  } item_t;

  function automatic logic [TallyW-1:0] sat_inc(input logic [TallyW-1:0] v);
    sat_inc = (v == TallyMax) ? v : v + TallyW'(1);
  endfunction

endpackage

[rtl/merge_sort_by_date_with_stats.sv]
// date merge sorter: load, sort (copy each run to scratch, then read, wait and
// select per move), emit (read, wait, output per record). A set of N records
// yields min(N, MAX_RECORDS) results; next set loads while the queue has room.
// rst_ni clears all control state asynchronously; stores need no reset.
// results are single-cycle strobes; the receiver cannot stall.
module merge_sort_by_date_with_stats
  import msd_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       date_key_i,
  input  logic [15:0]       record_id_i,
  input  logic              last_record_i,
  output logic              result_valid_o,
  output logic [31:0]       sorted_key_o,
  output logic [15:0]       sorted_id_o,
  output logic              end_of_run_o,
  output logic [8:0]        compare_count_o,
  output logic [8:0]        move_count_o,
  output logic              overflow_o
);

  item_t in_item, head;
  logic  avail, pop;
  rec_t  rec;

  assign in_item = '{rec: '{key: date_key_i, id: record_id_i}, last: last_record_i};

  // front queue
  msd_front #(.Depth(4)) u_front (
    .clk_i, .rst_ni, .start_i(start), .item_i(in_item), .busy_o(busy),
    .pop_i(pop), .avail_o(avail), .head_o(head)
  );

  // sort engine
  msd_back #(.MaxRecords(MAX_RECORDS)) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .head_i(head), .pop_o(pop),
    .valid_o(result_valid_o), .rec_o(rec), .end_o(end_of_run_o),
    .cmp_o(compare_count_o), .mov_o(move_count_o), .ovf_o(overflow_o)
  );

  assign sorted_key_o = rec.key;
  assign sorted_id_o  = rec.id;

endmodule

[rtl/msd_front.sv]
// load front: accepts records and queues them for the sort engine
// depends on msd_pkg
module msd_front
  import msd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  output logic  busy_o,
  input  logic  pop_i,
  output logic  avail_o,
  output item_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  item_t           fifo_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  // stop taking items once a set end is queued until the back drains it
  logic            hold_q;

  logic push;
  assign push    = start_i && !busy_o;
  assign busy_o  = (cnt_q == (PtrW+1)'(Depth)) || hold_q;
  assign avail_o = cnt_q != '0;
  assign head_o  = fifo_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= item_i;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      hold_q <= 1'b0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop_i);
      if (push && item_i.last) hold_q <= 1'b1;
      else if (pop_i && head_o.last) hold_q <= 1'b0;
    end
  end

endmodule

[rtl/msd_back.sv]
// sort back: stores records, runs a top-down merge sort, emits
// depends on msd_pkg
module msd_back
  import msd_pkg::*;
#(
  parameter int unsigned MaxRecords = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  item_t             head_i,
  output logic              pop_o,
  output logic              valid_o,
  output rec_t              rec_o,
  output logic              end_o,
  output logic [TallyW-1:0] cmp_o,
  output logic [TallyW-1:0] mov_o,
  output logic              ovf_o
);

  localparam int unsigned AW  = $clog2(MaxRecords);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned SD  = AW + 2;
  localparam int unsigned SW  = $clog2(SD + 1);
  localparam int unsigned SIW = $clog2(SD);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CALL  = 4'd1;
  localparam logic [3:0] S_RET   = 4'd2;
  localparam logic [3:0] S_COPY  = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_MSEL  = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_EWAIT = 4'd8;
  localparam logic [3:0] S_EOUT  = 4'd9;

  rec_t main_mem [MaxRecords];
  rec_t scr_mem  [MaxRecords];

  // recursion frame: range and phase (0 new, 1 left done, 2 right done)
  typedef struct packed {
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
    logic [1:0]    ph;
  } frame_t;
  frame_t stk_q [SD];
  logic [SW-1:0] sp_q;

  logic [3:0]        st_q;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic [TallyW-1:0] cmp_q, mov_q;
  logic [AW-1:0]     lo_q, mid_q, hi_q, a_q, b_q, k_q, i_q;
  logic              a_end_q, b_end_q;
  // last element of the run has been read for the copy
  logic              cp_end_q;
  rec_t              ra_q, rb_q, main_rd_q;

  // stack slots: current top and the next free one
  logic [SIW-1:0] tp_idx, sp_idx;
  assign tp_idx = SIW'(sp_q - SW'(1));
  assign sp_idx = SIW'(sp_q);

  frame_t top;
  assign top = stk_q[tp_idx];
  logic [AW-1:0] tmid;
  assign tmid = top.lo + ((top.hi - top.lo) >> 1);

  assign pop_o = (st_q == S_LOAD) && avail_i;

  // main store: load writes, merge writes, copy and emit read
  always_ff @(posedge clk_i) begin
    if (pop_o && cnt_q != CW'(MaxRecords)) main_mem[cnt_q[AW-1:0]] <= head_i.rec;
    if (st_q == S_MSEL) begin
      if (!a_end_q && (b_end_q || ra_q.key <= rb_q.key)) main_mem[k_q] <= ra_q;
      else main_mem[k_q] <= rb_q;
    end
    main_rd_q <= main_mem[i_q];
  end

  // scratch store: copied run, read at both run heads
  always_ff @(posedge clk_i) begin
    if (st_q == S_COPY && (i_q != lo_q || cp_end_q)) scr_mem[i_q - AW'(1)] <= main_rd_q;
    ra_q <= scr_mem[a_q];
    rb_q <= scr_mem[b_q];
  end

  // output register
  always_ff @(posedge clk_i) rec_o <= main_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; ovf_q <= 1'b0; cmp_q <= '0; mov_q <= '0;
      sp_q <= '0; valid_o <= 1'b0; end_o <= 1'b0; cmp_o <= '0; mov_o <= '0;
      ovf_o <= 1'b0; lo_q <= '0; mid_q <= '0; hi_q <= '0; a_q <= '0; b_q <= '0;
      k_q <= '0; i_q <= '0; a_end_q <= 1'b0; b_end_q <= 1'b0; cp_end_q <= 1'b0;
      for (int j = 0; j < SD; j++) stk_q[j] <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (st_q)
        // collect records until the set end
        S_LOAD: if (pop_o) begin
          logic [CW-1:0] n;
          n = cnt_q;
          if (cnt_q != CW'(MaxRecords)) begin
            n = cnt_q + CW'(1);
            cnt_q <= n;
          end else ovf_q <= 1'b1;
          if (head_i.last) begin
            if (n > CW'(1)) begin
              stk_q[0] <= '{lo: '0, hi: AW'(n - CW'(1)), ph: 2'd0};
              sp_q <= SW'(1);
              st_q <= S_CALL;
            end else if (n == CW'(1)) begin
              i_q <= '0; st_q <= S_ERD;
            end else begin
              cnt_q <= '0; ovf_q <= 1'b0; cmp_q <= '0; mov_q <= '0;
            end
          end
        end
        // walk the split stack
        S_CALL: begin
          if (top.ph == 2'd0) begin
            stk_q[tp_idx].ph <= 2'd1;
            if (top.lo != tmid) begin
              stk_q[sp_idx] <= '{lo: top.lo, hi: tmid, ph: 2'd0};
              sp_q <= sp_q + SW'(1);
            end
          end else if (top.ph == 2'd1) begin
            stk_q[tp_idx].ph <= 2'd2;
            if (tmid + AW'(1) != top.hi) begin
              stk_q[sp_idx] <= '{lo: tmid + AW'(1), hi: top.hi, ph: 2'd0};
              sp_q <= sp_q + SW'(1);
            end
          end else begin
            lo_q <= top.lo; mid_q <= tmid; hi_q <= top.hi;
            i_q <= top.lo; cp_end_q <= 1'b0; st_q <= S_COPY;
          end
        end
        // copy run to scratch, one read ahead
        S_COPY: begin
          if (cp_end_q) begin
            cp_end_q <= 1'b0;
            a_q <= lo_q; b_q <= mid_q + AW'(1); k_q <= lo_q;
            a_end_q <= 1'b0; b_end_q <= 1'b0; st_q <= S_MRD;
          end else begin
            if (i_q == hi_q) cp_end_q <= 1'b1;
            i_q <= i_q + AW'(1);
          end
        end
        S_MRD:   st_q <= S_MWAIT;
        S_MWAIT: st_q <= S_MSEL;
        // pick one element per merge step
        S_MSEL: begin
          logic take_a;
          take_a = !a_end_q && (b_end_q || ra_q.key <= rb_q.key);
          if (!a_end_q && !b_end_q) cmp_q <= sat_inc(cmp_q);
          mov_q <= sat_inc(mov_q);
          if (take_a) begin
            if (a_q == mid_q) a_end_q <= 1'b1; else a_q <= a_q + AW'(1);
          end else begin
            if (b_q == hi_q) b_end_q <= 1'b1; else b_q <= b_q + AW'(1);
          end
          if (k_q == hi_q) begin
            st_q <= S_RET;
          end else begin
            k_q <= k_q + AW'(1); st_q <= S_MRD;
          end
        end
        // frame done
        S_RET: begin
          if (sp_q == SW'(1)) begin
            sp_q <= '0; i_q <= '0; st_q <= S_ERD;
          end else begin
            sp_q <= sp_q - SW'(1); st_q <= S_CALL;
          end
        end
        S_ERD:   st_q <= S_EWAIT;
        S_EWAIT: st_q <= S_EOUT;
        // emit one sorted record
        S_EOUT: begin
          valid_o <= 1'b1;
          end_o <= (CW'(i_q) + CW'(1) == cnt_q);
          cmp_o <= cmp_q; mov_o <= mov_q; ovf_o <= ovf_q;
          if (CW'(i_q) + CW'(1) == cnt_q) begin
            cnt_q <= '0; ovf_q <= 1'b0; cmp_q <= '0; mov_q <= '0;
            st_q <= S_LOAD;
          end else begin
            i_q <= i_q + AW'(1); st_q <= S_ERD;
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

endmodule

[rtl/msd_checker.sv]
// port-level checks for the date merge sorter
// depends on merge_sort_by_date_with_stats ports
module msd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic        end_of_run_o,
  input logic [8:0]  compare_count_o,
  input logic [8:0]  move_count_o
);

  // results are never back to back: the read and wait states lie between them
  a_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back to back results");

  // the compare tally holds across one set
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !end_of_run_o |=> ##2 (!result_valid_o ||
      $stable(compare_count_o))) else $error("compare tally changed in set");

  // compares never exceed moves
  a_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> compare_count_o <= move_count_o) else $error("tallies");

endmodule

bind merge_sort_by_date_with_stats msd_checker u_msd_checker (.*);

[tb/tb_merge_sort_by_date_with_stats.sv]
// testbench for the date merge sorter: directed and random record sets
// predicts sorted order and tallies itself; depends on msd_pkg and the rtl top
module tb_merge_sort_by_date_with_stats;
  import msd_pkg::*;

  localparam int unsigned Cap = 64;

  typedef struct {
    logic [31:0] key;
    logic [15:0] id;
    logic        eor;
    logic [8:0]  cmps;
    logic [8:0]  moves;
    logic        ovf;
  } sorted_rec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] date_key_i;
  logic [15:0] record_id_i;
  logic        last_record_i;
  logic        result_valid_o;
  logic [31:0] sorted_key_o;
  logic [15:0] sorted_id_o;
  logic        end_of_run_o;
  logic [8:0]  compare_count_o;
  logic [8:0]  move_count_o;
  logic        overflow_o;

  // predictor state
  logic [31:0] set_keys [Cap];
  logic [15:0] set_ids  [Cap];
  logic [31:0] tmp_keys [Cap];
  logic [15:0] tmp_ids  [Cap];
  int unsigned set_len;
  logic [8:0]  cmp_tally;
  logic [8:0]  mov_tally;
  logic        ovf_flag;

  // ring of expected result transactions
  sorted_rec_t exp_buf [256];
  logic [7:0]  exp_wr;
  logic [7:0]  exp_rd;
  int          mismatches;
  int          idle_pct;

  merge_sort_by_date_with_stats #(.MAX_RECORDS(Cap)) DUT (.*);

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [8:0] sat9(input logic [8:0] v);
    return (v == 9'h1ff) ? v : v + 9'd1;
  endfunction

  // merge two adjacent sorted runs, left wins on ties
  function automatic void merge_halves(int unsigned lo, int unsigned mid, int unsigned hi);
    int unsigned a, b, k;
    for (int unsigned i = lo; i <= hi; i++) begin
      tmp_keys[i] = set_keys[i];
      tmp_ids[i]  = set_ids[i];
    end
    a = lo;
    b = mid + 1;
    k = lo;
    while (a <= mid && b <= hi) begin
      cmp_tally = sat9(cmp_tally);
      if (tmp_keys[a] <= tmp_keys[b]) begin
        set_keys[k] = tmp_keys[a];
        set_ids[k] = tmp_ids[a];
        a++;
      end else begin
        set_keys[k] = tmp_keys[b];
        set_ids[k] = tmp_ids[b];
        b++;
      end
      mov_tally = sat9(mov_tally);
      k++;
    end
    while (a <= mid) begin
      set_keys[k] = tmp_keys[a];
      set_ids[k] = tmp_ids[a];
      a++;
      k++;
      mov_tally = sat9(mov_tally);
    end
    while (b <= hi) begin
      set_keys[k] = tmp_keys[b];
      set_ids[k] = tmp_ids[b];
      b++;
      k++;
      mov_tally = sat9(mov_tally);
    end
  endfunction

  function automatic void sort_span(int unsigned lo, int unsigned hi);
    int unsigned mid;
    if (lo >= hi) return;
    mid = lo + (hi - lo) / 2;
    sort_span(lo, mid);
    sort_span(mid + 1, hi);
    merge_halves(lo, mid, hi);
  endfunction

  // append one expected result transaction
  function automatic void queue_expected(sorted_rec_t r);
    exp_buf[exp_wr] = r;
    exp_wr = exp_wr + 8'd1;
  endfunction

  // update predictor for one accepted record
  function automatic void predict_record(logic [31:0] key, logic [15:0] id, logic last);
    sorted_rec_t r;
    if (set_len < Cap) begin
      set_keys[set_len] = key;
      set_ids[set_len] = id;
      set_len++;
    end else begin
      ovf_flag = 1'b1;
    end
    if (!last) return;
    if (set_len > 0) sort_span(0, set_len - 1);
    for (int unsigned k = 0; k < set_len; k++) begin
      r.key = set_keys[k];
      r.id = set_ids[k];
      r.eor = (k + 1 == set_len);
      r.cmps = cmp_tally;
      r.moves = mov_tally;
      r.ovf = ovf_flag;
      queue_expected(r);
    end
    set_len = 0;
    cmp_tally = '0;
    mov_tally = '0;
    ovf_flag = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("error: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    sorted_rec_t e;
    if (rst_ni && result_valid_o) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected result key", sorted_key_o, 32'h0);
      end else begin
        e = exp_buf[exp_rd];
        exp_rd = exp_rd + 8'd1;
        if (sorted_key_o !== e.key) report_mismatch("sorted_key", sorted_key_o, e.key);
        if (sorted_id_o !== e.id)
          report_mismatch("sorted_id", 32'(sorted_id_o), 32'(e.id));
        if (end_of_run_o !== e.eor)
          report_mismatch("end_of_run", 32'(end_of_run_o), 32'(e.eor));
        if (compare_count_o !== e.cmps)
          report_mismatch("compare_count", 32'(compare_count_o), 32'(e.cmps));
        if (move_count_o !== e.moves)
          report_mismatch("move_count", 32'(move_count_o), 32'(e.moves));
        if (overflow_o !== e.ovf)
          report_mismatch("overflow", 32'(overflow_o), 32'(e.ovf));
      end
    end
  end

  // send one record transaction, with random idle before it
  task automatic send_record(input logic [31:0] key, input logic [15:0] id,
                             input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    date_key_i <= key;
    record_id_i <= id;
    last_record_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_record(key, id, last);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_date();
    logic [31:0] d;
    d[31:16] = 16'h1990 + 16'($urandom_range(0, 9));
    d[15:8] = 8'($urandom_range(1, 12));
    d[7:0] = 8'($urandom_range(1, 4));
    return d;
  endfunction

  task automatic send_set(input int unsigned n, input bit full_range);
    logic [31:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      k = full_range ? $urandom() : rand_date();
      send_record(k, 16'($urandom()), i + 1 == n);
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_record(32'h2024_0101, 16'h0001, 1'b1);
    send_record(32'hffff_ffff, 16'hffff, 1'b0);
    send_record(32'h0000_0000, 16'h0000, 1'b0);
    send_record(32'h2020_0505, 16'h1234, 1'b0);
    send_record(32'h2020_0505, 16'h5678, 1'b0);
    send_record(32'h2020_0505, 16'h9abc, 1'b0);
    send_record(32'h1999_1231, 16'haaaa, 1'b1);
    wait_drain();
    send_record(32'h2000_0101, 16'h5555, 1'b0);
    send_record(32'h1999_0101, 16'h0f0f, 1'b1);
  endtask

  task automatic test_overflow();
    idle_pct = 0;
    send_set(Cap + 3, 1'b0);
    // full set then a dropped last record
    send_set(Cap, 1'b1);
    for (int unsigned i = 0; i < Cap; i++)
      send_record(rand_date(), 16'(i), 1'b0);
    send_record(32'h0000_0001, 16'hbeef, 1'b1);
  endtask

  task automatic test_random(input int pct, input int nsets);
    idle_pct = pct;
    for (int s = 0; s < nsets; s++)
      send_set($urandom_range(1, 10), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    date_key_i = '0;
    record_id_i = '0;
    last_record_i = 1'b0;
    set_len = 0;
    cmp_tally = '0;
    mov_tally = '0;
    ovf_flag = 1'b0;
    exp_wr = '0;
    exp_rd = '0;
    mismatches = 0;
    idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 15);
    wait_drain();
    test_random(56, 15);
    test_random(6, 10);
    test_random(0, 5);
    wait_drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
